/* rtl/sss_pkg.sv */
// ----------------------------------------------------------------------------
// sss_pkg
// Shared types and constants for the servo sweep range scanner.
// ----------------------------------------------------------------------------
package sss_pkg;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_START = 2'd1,
        CMD_STOP  = 2'd2
    } sss_cmd_t;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_STARTED = 3'd1,
        EV_SAMPLE  = 3'd2,
        EV_DONE    = 3'd3,
        EV_INTR    = 3'd4
    } sss_event_t;

    typedef enum logic [2:0] {
        REG_FORWARD_ANGLE = 3'd0,
        REG_MIN_ANGLE     = 3'd1,
        REG_MAX_ANGLE     = 3'd2,
        REG_STEP_ANGLE    = 3'd3,
        REG_STEP_PERIOD   = 3'd4
    } sss_reg_idx_t;

    localparam logic [7:0]  FORWARD_ANGLE_RST = 8'd90;
    localparam logic [7:0]  MIN_ANGLE_RST     = 8'd0;
    localparam logic [7:0]  MAX_ANGLE_RST     = 8'd180;
    localparam logic [6:0]  STEP_ANGLE_RST    = 7'd5;
    localparam logic [15:0] STEP_PERIOD_RST   = 16'd100;

    localparam logic signed [13:0] NO_DISTANCE = -14'sd1;

    typedef struct packed {
        logic [7:0]  forward_angle;
        logic [7:0]  min_angle;
        logic [7:0]  max_angle;
        logic [6:0]  step_angle;
        logic [15:0] step_period_ticks;
    } sss_cfg_t;

    typedef struct packed {
        logic [2:0]         event_res;
        logic [7:0]         servo_angle;
        logic               servo_enable;
        logic signed [8:0]  sample_angle;
        logic signed [13:0] sample_distance;
        logic signed [13:0] forward_distance;
        logic               busy_res;
    } sss_result_t;

endpackage

/* rtl/servo_sweep_range_scanner.sv */
// ----------------------------------------------------------------------------
// servo_sweep_range_scanner
// Each result is registered in the output register, or in the skid register while m_axis is stalled.
// Throughput: one item per cycle while the skid register is empty; the sweep
// update is a single pass of compare/add logic between the state and output registers.
// A skid register keeps s_axis_tready independent of m_axis_tready.
// Reset: rst_n clears the sweep, restores registers to defaults, servo at 90.
// ----------------------------------------------------------------------------
module servo_sweep_range_scanner
(
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // item input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // start_from[8:0], start_to[17:9], distance_mm[31:18]
    input  logic [1:0]  s_axis_tuser,   // command[1:0]
    // result output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // servo_angle[7:0], servo_enable[8],
                                        // sample_angle[17:9], sample_distance[31:18],
                                        // forward_distance[45:32], busy_res[46], zero[47]
    output logic [2:0]  m_axis_tuser    // event_res[2:0]
);
    import sss_pkg::*;

    sss_cfg_t    cfg_reg;
    sss_result_t core_res;
    sss_result_t out_reg, skid_reg;
    logic        out_valid_reg, skid_valid_reg;
    logic        s_accept, m_accept, cfg_write;
    logic [2:0]  reg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign reg_idx   = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.forward_angle     <= FORWARD_ANGLE_RST;
            cfg_reg.min_angle         <= MIN_ANGLE_RST;
            cfg_reg.max_angle         <= MAX_ANGLE_RST;
            cfg_reg.step_angle        <= STEP_ANGLE_RST;
            cfg_reg.step_period_ticks <= STEP_PERIOD_RST;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                REG_FORWARD_ANGLE: cfg_reg.forward_angle     <= pwdata[7:0];
                REG_MIN_ANGLE:     cfg_reg.min_angle         <= pwdata[7:0];
                REG_MAX_ANGLE:     cfg_reg.max_angle         <= pwdata[7:0];
                REG_STEP_ANGLE:    cfg_reg.step_angle        <= pwdata[6:0];
                REG_STEP_PERIOD:   cfg_reg.step_period_ticks <= pwdata[15:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_FORWARD_ANGLE: prdata = {24'd0, cfg_reg.forward_angle};
            REG_MIN_ANGLE:     prdata = {24'd0, cfg_reg.min_angle};
            REG_MAX_ANGLE:     prdata = {24'd0, cfg_reg.max_angle};
            REG_STEP_ANGLE:    prdata = {25'd0, cfg_reg.step_angle};
            REG_STEP_PERIOD:   prdata = {16'd0, cfg_reg.step_period_ticks};
            default:           prdata = '0;
        endcase
    end

    assign s_axis_tready = !skid_valid_reg;
    assign s_accept      = s_axis_tvalid & s_axis_tready;
    assign m_accept      = out_valid_reg & m_axis_tready;

    sss_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_accept (s_accept),
        .command     (s_axis_tuser),
        .start_from  (s_axis_tdata[8:0]),
        .start_to    (s_axis_tdata[17:9]),
        .distance_mm (s_axis_tdata[31:18]),
        .cfg         (cfg_reg),
        .result      (core_res)
    );

    // output register plus skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_accept)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= s_accept;
            end
        end
        else if (s_accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_accept)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (s_accept)
                out_reg <= core_res;
        end
        else if (s_accept)
        begin
            skid_reg <= core_res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.event_res;
    assign m_axis_tdata  = {1'b0,
                            out_reg.busy_res,
                            out_reg.forward_distance,
                            out_reg.sample_distance,
                            out_reg.sample_angle,
                            out_reg.servo_enable,
                            out_reg.servo_angle};

`ifndef SYNTHESIS
    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a result ahead of the output register");

    a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && out_valid_reg && !m_axis_tready) |=> skid_valid_reg)
        else $error("result lost while output stalled");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && m_axis_tready) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid result not moved to output");
`endif

endmodule

/* rtl/sss_core.sv */
// ----------------------------------------------------------------------------
// sss_core
// Sweep state and per-item next-state logic; one item per cycle while item_accept is high.
// ----------------------------------------------------------------------------
module sss_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_accept,
    input  logic [1:0]          command,
    input  logic signed [8:0]   start_from,
    input  logic signed [8:0]   start_to,
    input  logic signed [13:0]  distance_mm,
    input  sss_pkg::sss_cfg_t   cfg,
    output sss_pkg::sss_result_t result
);
    import sss_pkg::*;

    logic               busy_reg, busy_next;
    logic [7:0]         from_reg, from_next;
    logic [7:0]         to_reg, to_next;
    logic signed [9:0]  cur_reg, cur_next;
    logic               neg_reg, neg_next;
    logic [15:0]        tick_reg, tick_next;
    logic signed [13:0] fwd_rd_reg, fwd_rd_next;
    logic [7:0]         pos_reg, pos_next;
    logic               attached_reg, attached_next;

    logic [7:0]         from_clamp, to_clamp;
    logic [15:0]        tick_inc;
    logic               step_due;
    logic signed [10:0] off, off_abs, cur_adv;
    logic               passed;

    // Clamp a servo-frame angle; when min > max, values below min give min and all others give max
    function automatic logic [7:0] clamp_angle(input logic signed [10:0] v,
                                               input logic [7:0] lo,
                                               input logic [7:0] hi);
        logic [7:0] r;
        if (v < $signed({3'b000, lo}))
            r = lo;
        else if (v > $signed({3'b000, hi}))
            r = hi;
        else
            r = v[7:0];
        return r;
    endfunction

    always_comb
    begin
        from_clamp = clamp_angle($signed({3'b000, cfg.forward_angle})
                                 + {{2{start_from[8]}}, start_from},
                                 cfg.min_angle, cfg.max_angle);
        to_clamp   = clamp_angle($signed({3'b000, cfg.forward_angle})
                                 + {{2{start_to[8]}}, start_to},
                                 cfg.min_angle, cfg.max_angle);
        tick_inc   = (tick_reg == 16'hFFFF) ? tick_reg : tick_reg + 16'd1;
        step_due   = (tick_inc >= cfg.step_period_ticks);
        off        = {cur_reg[9], cur_reg} - $signed({3'b000, cfg.forward_angle});
        off_abs    = off[10] ? -off : off;
        cur_adv    = neg_reg ? ({cur_reg[9], cur_reg} - $signed({4'b0000, cfg.step_angle}))
                             : ({cur_reg[9], cur_reg} + $signed({4'b0000, cfg.step_angle}));
        passed     = neg_reg ? (cur_adv < $signed({3'b000, to_reg}))
                             : (cur_adv > $signed({3'b000, to_reg}));
    end

    always_comb
    begin
        busy_next     = busy_reg;
        from_next     = from_reg;
        to_next       = to_reg;
        cur_next      = cur_reg;
        neg_next      = neg_reg;
        tick_next     = tick_reg;
        fwd_rd_next   = fwd_rd_reg;
        pos_next      = pos_reg;
        attached_next = attached_reg;
        result.event_res       = EV_NONE;
        result.sample_angle    = '0;
        result.sample_distance = '0;

        case (command)
            CMD_START:
            begin
                from_next = from_clamp;
                to_next   = to_clamp;
                cur_next  = $signed({2'b00, from_clamp});
                neg_next  = (to_clamp < from_clamp);
                busy_next = 1'b1;
                tick_next = '0;
                if (from_clamp != pos_reg)
                begin
                    pos_next      = from_clamp;
                    attached_next = 1'b1;
                end
                result.event_res = EV_STARTED;
            end
            CMD_STOP:
            begin
                if (busy_reg)
                begin
                    busy_next        = 1'b0;
                    pos_next         = cfg.forward_angle;
                    attached_next    = 1'b0;
                    result.event_res = EV_INTR;
                end
            end
            CMD_TICK:
            begin
                if (busy_reg)
                begin
                    tick_next = tick_inc;
                    if (step_due)
                    begin
                        tick_next     = '0;
                        pos_next      = cur_reg[7:0];
                        attached_next = attached_reg | (cur_reg[7:0] != pos_reg);
                        result.sample_angle    = off[8:0];
                        result.sample_distance = distance_mm;
                        if (off_abs <= $signed({4'b0000, cfg.step_angle}))
                            fwd_rd_next = distance_mm;
                        cur_next = cur_adv[9:0];
                        result.event_res = EV_SAMPLE;
                        if (passed)
                        begin
                            busy_next     = 1'b0;
                            attached_next = 1'b0;
                            if (from_reg != to_reg)
                                pos_next = cfg.forward_angle;
                            result.event_res = EV_DONE;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase

        result.servo_angle      = pos_next;
        result.servo_enable     = attached_next;
        result.forward_distance = fwd_rd_next;
        result.busy_res         = busy_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            from_reg     <= '0;
            to_reg       <= '0;
            cur_reg      <= '0;
            neg_reg      <= 1'b0;
            tick_reg     <= '0;
            fwd_rd_reg   <= NO_DISTANCE;
            pos_reg      <= FORWARD_ANGLE_RST;
            attached_reg <= 1'b0;
        end
        else if (item_accept)
        begin
            busy_reg     <= busy_next;
            from_reg     <= from_next;
            to_reg       <= to_next;
            cur_reg      <= cur_next;
            neg_reg      <= neg_next;
            tick_reg     <= tick_next;
            fwd_rd_reg   <= fwd_rd_next;
            pos_reg      <= pos_next;
            attached_reg <= attached_next;
        end
    end

`ifndef SYNTHESIS
    a_attached_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        attached_reg |-> busy_reg)
        else $error("servo drive attached outside a sweep");

    a_stop_clears_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (item_accept && command == CMD_STOP) |=> (!busy_reg && !attached_reg))
        else $error("stop left sweep running");

    a_start_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (item_accept && command == CMD_START) |=> (busy_reg && tick_reg == 16'd0))
        else $error("start did not arm sweep");
`endif

endmodule
